// ===== src/bss_pkg.sv =====
// Shared types and constants for the box set statistics block.
package bss_pkg;

    localparam int CoordW   = 16;
    localparam int SideW    = 16;
    localparam int SumW     = 32;
    localparam int VolW     = 48;
    localparam int SmallW   = 49;
    localparam int TotalW   = 64;
    localparam int CountW   = 17;
    localparam int ValW     = 49;
    localparam int CodeW    = 5;
    localparam int InDataW  = 6 * CoordW;
    localparam int OutDataW = 56;
    localparam int DivCntW  = 7;

    localparam logic [CountW-1:0] MAX_BOXES  = CountW'(65536);
    localparam logic [VolW-1:0]   RATIO_SAT  = {VolW{1'b1}};

    // statistic codes (first code of each group)
    localparam logic [CodeW-1:0] ST_SIDE_MAX   = 5'd0;
    localparam logic [CodeW-1:0] ST_SIDE_MIN   = 5'd3;
    localparam logic [CodeW-1:0] ST_SIDE_AVG   = 5'd6;
    localparam logic [CodeW-1:0] ST_CORNER_MIN = 5'd9;
    localparam logic [CodeW-1:0] ST_CORNER_MAX = 5'd12;
    localparam logic [CodeW-1:0] ST_BIG_VOL    = 5'd15;
    localparam logic [CodeW-1:0] ST_BIG_IDX    = 5'd16;
    localparam logic [CodeW-1:0] ST_BIG_SIDE   = 5'd17;
    localparam logic [CodeW-1:0] ST_SMALL_VOL  = 5'd20;
    localparam logic [CodeW-1:0] ST_SMALL_IDX  = 5'd21;
    localparam logic [CodeW-1:0] ST_SMALL_SIDE = 5'd22;
    localparam logic [CodeW-1:0] ST_AVG_VOL    = 5'd25;
    localparam logic [CodeW-1:0] ST_RATIO      = 5'd26;

    // divider jobs: 0..2 side averages per axis
    localparam logic [2:0] DIV_SIDE_X  = 3'd0;
    localparam logic [2:0] DIV_AVG_VOL = 3'd3;
    localparam logic [2:0] DIV_RATIO   = 3'd4;

    typedef struct packed {
        logic             load_in;
        logic             mul1;
        logic             mul2;
        logic             acc;
        logic             clear;
        logic             div_start;
        logic             div_store;
        logic [2:0]       div_sel;
        logic             load_out;
        logic [CodeW-1:0] stat_code;
    } dp_cmd_t;

    typedef struct packed {
        logic final_box;
        logic div_done;
    } dp_sts_t;

endpackage

// ===== src/bss_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module bss_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bss_pkg::TotalW-1:0]   dividend,
    input  logic [bss_pkg::SmallW-1:0]   divisor,
    output logic                         done,
    output logic [bss_pkg::TotalW-1:0]   quotient
);
    import bss_pkg::*;

    logic [TotalW-1:0]  q_reg, q_next;
    logic [SmallW-1:0]  rem_reg, rem_next;
    logic [SmallW-1:0]  dvs_reg;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [SmallW:0]    shifted;
    logic [SmallW:0]    trial;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[TotalW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = DivCntW'(TotalW);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[SmallW])
            begin
                rem_next = trial[SmallW-1:0];
                q_next   = {q_reg[TotalW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SmallW-1:0];
                q_next   = {q_reg[TotalW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DivCntW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/bss_datapath.sv =====
// Datapath: sides, volume, accumulators, divider jobs and output word register.
module bss_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bss_pkg::dp_cmd_t               cmd,
    output bss_pkg::dp_sts_t               sts,
    input  logic [bss_pkg::InDataW-1:0]    in_data,
    input  logic                           in_last,
    output logic [bss_pkg::ValW-1:0]       out_value,
    output logic [bss_pkg::CodeW-1:0]      out_code,
    output logic                           out_last
);
    import bss_pkg::*;

    logic signed [CoordW-1:0] lo_reg [3];
    logic signed [CoordW-1:0] hi_reg [3];
    logic                     final_reg;
    logic [SideW-1:0]         side_reg [3];
    logic [2*SideW-1:0]       prod_reg;
    logic [VolW-1:0]          vol_reg;

    logic [SideW-1:0]         side_max_reg [3];
    logic [SideW-1:0]         side_min_reg [3];
    logic [SumW-1:0]          side_sum_reg [3];
    logic signed [CoordW-1:0] corner_min_reg [3];
    logic signed [CoordW-1:0] corner_max_reg [3];
    logic [VolW-1:0]          big_vol_reg;
    logic [CountW-1:0]        big_idx_reg;
    logic [SideW-1:0]         big_side_reg [3];
    logic [SmallW-1:0]        small_vol_reg;
    logic [CountW-1:0]        small_idx_reg;
    logic [SideW-1:0]         small_side_reg [3];
    logic [TotalW-1:0]        total_reg;
    logic [CountW-1:0]        count_reg;

    logic [SideW-1:0]         avg_side_reg [3];
    logic [VolW-1:0]          avg_vol_reg;
    logic [VolW-1:0]          ratio_reg;

    logic [ValW-1:0]          val_reg;
    logic [CodeW-1:0]         code_reg;
    logic                     last_reg;

    logic [SideW-1:0]         side_c [3];
    logic [TotalW-1:0]        div_dvd;
    logic [SmallW-1:0]        div_dvs;
    logic                     div_done;
    logic [TotalW-1:0]        div_q;
    logic                     take;
    logic [ValW-1:0]          val_c;
    logic [1:0]               ax;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (hi_reg[a] < lo_reg[a])
                side_c[a] = '0;
            else
                side_c[a] = SideW'(hi_reg[a] - lo_reg[a]);
        end
    end

    assign take = (count_reg < MAX_BOXES);

    bss_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        div_dvd = total_reg;
        div_dvs = SmallW'(count_reg);
        unique case (cmd.div_sel)
            DIV_AVG_VOL:
                div_dvd = total_reg;
            DIV_RATIO:
            begin
                div_dvd = TotalW'(big_vol_reg);
                div_dvs = small_vol_reg;
            end
            default:
                if (cmd.div_sel < DIV_AVG_VOL)
                    div_dvd = TotalW'(side_sum_reg[cmd.div_sel[1:0]]);
        endcase
    end

    // statistic word selection
    always_comb
    begin
        val_c = '0;
        ax    = '0;
        priority if (cmd.stat_code < ST_SIDE_MIN)
        begin
            ax    = 2'(cmd.stat_code - ST_SIDE_MAX);
            val_c = ValW'(side_max_reg[ax]);
        end
        else if (cmd.stat_code < ST_SIDE_AVG)
        begin
            ax    = 2'(cmd.stat_code - ST_SIDE_MIN);
            val_c = ValW'(side_min_reg[ax]);
        end
        else if (cmd.stat_code < ST_CORNER_MIN)
        begin
            ax    = 2'(cmd.stat_code - ST_SIDE_AVG);
            val_c = ValW'(avg_side_reg[ax]);
        end
        else if (cmd.stat_code < ST_CORNER_MAX)
        begin
            ax    = 2'(cmd.stat_code - ST_CORNER_MIN);
            val_c = ValW'(signed'(corner_min_reg[ax]));
        end
        else if (cmd.stat_code < ST_BIG_VOL)
        begin
            ax    = 2'(cmd.stat_code - ST_CORNER_MAX);
            val_c = ValW'(signed'(corner_max_reg[ax]));
        end
        else if (cmd.stat_code == ST_BIG_VOL)
            val_c = ValW'(big_vol_reg);
        else if (cmd.stat_code == ST_BIG_IDX)
            val_c = ValW'(signed'(big_idx_reg));
        else if (cmd.stat_code < ST_SMALL_VOL)
        begin
            ax    = 2'(cmd.stat_code - ST_BIG_SIDE);
            val_c = ValW'(big_side_reg[ax]);
        end
        else if (cmd.stat_code == ST_SMALL_VOL)
            val_c = small_vol_reg;
        else if (cmd.stat_code == ST_SMALL_IDX)
            val_c = ValW'(signed'(small_idx_reg));
        else if (cmd.stat_code < ST_AVG_VOL)
        begin
            ax    = 2'(cmd.stat_code - ST_SMALL_SIDE);
            val_c = ValW'(small_side_reg[ax]);
        end
        else if (cmd.stat_code == ST_AVG_VOL)
            val_c = ValW'(avg_vol_reg);
        else
            val_c = ValW'(ratio_reg);
    end

    // item capture, products, divider results, output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= in_data[2*a*CoordW +: CoordW];
                hi_reg[a] <= in_data[(2*a+1)*CoordW +: CoordW];
            end
            final_reg <= in_last;
        end
        if (cmd.mul1)
        begin
            for (int a = 0; a < 3; a++)
                side_reg[a] <= side_c[a];
            prod_reg <= side_c[0] * side_c[1];
        end
        if (cmd.mul2)
            vol_reg <= prod_reg * side_reg[2];
        if (cmd.div_store)
        begin
            unique case (cmd.div_sel)
                DIV_AVG_VOL:
                    avg_vol_reg <= (count_reg == '0) ? '0 : div_q[VolW-1:0];
                DIV_RATIO:
                    ratio_reg <= (small_vol_reg == '0) ? RATIO_SAT : div_q[VolW-1:0];
                default:
                    if (cmd.div_sel < DIV_AVG_VOL)
                        avg_side_reg[cmd.div_sel[1:0]] <=
                            (count_reg == '0) ? '0 : div_q[SideW-1:0];
            endcase
        end
        if (cmd.load_out)
        begin
            val_reg  <= val_c;
            code_reg <= cmd.stat_code;
            last_reg <= (cmd.stat_code == ST_RATIO);
        end
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                side_max_reg[a]   <= '0;
                side_min_reg[a]   <= '1;
                side_sum_reg[a]   <= '0;
                corner_min_reg[a] <= 16'sh7fff;
                corner_max_reg[a] <= 16'sh8000;
                big_side_reg[a]   <= '0;
                small_side_reg[a] <= '0;
            end
            big_vol_reg   <= '0;
            big_idx_reg   <= '1;
            small_vol_reg <= '1;
            small_idx_reg <= '1;
            total_reg     <= '0;
            count_reg     <= '0;
        end
        else if (cmd.clear)
        begin
            for (int a = 0; a < 3; a++)
            begin
                side_max_reg[a]   <= '0;
                side_min_reg[a]   <= '1;
                side_sum_reg[a]   <= '0;
                corner_min_reg[a] <= 16'sh7fff;
                corner_max_reg[a] <= 16'sh8000;
                big_side_reg[a]   <= '0;
                small_side_reg[a] <= '0;
            end
            big_vol_reg   <= '0;
            big_idx_reg   <= '1;
            small_vol_reg <= '1;
            small_idx_reg <= '1;
            total_reg     <= '0;
            count_reg     <= '0;
        end
        else if (cmd.acc && take)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (side_reg[a] > side_max_reg[a])
                    side_max_reg[a] <= side_reg[a];
                if (side_reg[a] < side_min_reg[a])
                    side_min_reg[a] <= side_reg[a];
                side_sum_reg[a] <= side_sum_reg[a] + SumW'(side_reg[a]);
                if (lo_reg[a] < corner_min_reg[a])
                    corner_min_reg[a] <= lo_reg[a];
                if (hi_reg[a] > corner_max_reg[a])
                    corner_max_reg[a] <= hi_reg[a];
            end
            if (vol_reg > big_vol_reg)
            begin
                big_vol_reg <= vol_reg;
                big_idx_reg <= count_reg;
                for (int a = 0; a < 3; a++)
                    big_side_reg[a] <= side_reg[a];
            end
            if (SmallW'(vol_reg) < small_vol_reg)
            begin
                small_vol_reg <= SmallW'(vol_reg);
                small_idx_reg <= count_reg;
                for (int a = 0; a < 3; a++)
                    small_side_reg[a] <= side_reg[a];
            end
            total_reg <= total_reg + TotalW'(vol_reg);
            count_reg <= count_reg + 1'b1;
        end
    end

    assign sts.final_box = final_reg;
    assign sts.div_done  = div_done;
    assign out_value     = val_reg;
    assign out_code      = code_reg;
    assign out_last      = last_reg;

endmodule

// ===== src/bss_ctrl.sv =====
// Controller: sequences item steps, divider jobs and the statistics burst.
module bss_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bss_pkg::dp_cmd_t            cmd,
    input  bss_pkg::dp_sts_t            sts
);
    import bss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       sel_reg, sel_next;
    logic [CodeW-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        cmd.stat_code = idx_reg;
        valid_next    = out_ready ? 1'b0 : valid_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL1;
                end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc  = 1'b1;
                sel_next = DIV_SIDE_X;
                state_next = sts.final_box ? S_DIV_GO : S_IDLE;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == DIV_RATIO)
                    begin
                        idx_next   = ST_SIDE_MAX;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_DIV_GO;
                    end
                end
            S_EMIT:
                if (!valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    if (idx_reg == ST_RATIO)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

endmodule

// ===== src/box_set_statistics.sv =====
// Top level of the box set statistics block.
//
// Input stream: one axis-aligned box per word. s_axis_tdata carries the six
// signed 16-bit corner coordinates, s_axis_tlast marks the last box of a set.
// Each box passes through the capture, side/first product, second product and
// accumulate steps: a 16x16 multiply, then a 32x16 multiply, then the accumulator
// update; the next box is taken only after the accumulate step is done.
// On the last box the block runs five divisions (three side averages, the
// average volume and the volume ratio) on one shared restoring divider,
// then sends 27 statistic words on the output stream:
// m_axis_tuser holds the statistic code, m_axis_tdata the signed value,
// m_axis_tlast marks the ratio word. The burst runs one word a cycle while the
// receiver is ready.
// A stalled receiver holds the output register and pauses the burst; input is
// refused until the last word is loaded, after which the accumulators clear
// and new boxes are taken while that word still waits.
// Reset clears all accumulators and any burst in progress.
module box_set_statistics (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // low_x, high_x, low_y, high_y, low_z, high_z
    input  logic        s_axis_tlast,   // final_box
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // stat_value[48:0], zero pad
    output logic [4:0]  m_axis_tuser,   // stat_code
    output logic        m_axis_tlast    // final_stat
);
    import bss_pkg::*;

    dp_cmd_t         cmd;
    dp_sts_t         sts;
    logic [ValW-1:0] value;

    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bss_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_value (value),
        .out_code  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OutDataW-ValW){1'b0}}, value};

endmodule
